// ===== rtl/bidirectional_motor_ramp_limiter_macros.svh =====
// Assertion macros shared by the ramp limiter checker.
`ifndef BIDIRECTIONAL_MOTOR_RAMP_LIMITER_MACROS_SVH
`define BIDIRECTIONAL_MOTOR_RAMP_LIMITER_MACROS_SVH

// Property checked only outside reset.
`define BMRL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked in every cycle, reset included.
`define BMRL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bmrl_pkg.sv =====
// Types, constants and helper functions for the motor ramp limiter.
`default_nettype none

package bmrl_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_FWD  = 2'd1,
    ACT_REV  = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [3:0] REG_UPDATE_INTERVAL = 4'd0;
  localparam logic [3:0] REG_STOP_STEP       = 4'd1;

  localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd100;
  localparam logic [15:0] STOP_STEP_RST       = 16'd1638;

  // Q1.15 levels
  localparam logic [15:0] ONE_Q15     = 16'd32768;
  localparam logic [15:0] HALF_Q15    = 16'd16384;
  localparam logic [15:0] KNEE_LEVEL  = 16'd17630;
  localparam logic [15:0] COEF_HIGH   = 16'd7098;
  localparam logic [15:0] COEF_LOW    = 16'd54768;
  localparam logic [31:0] ROUND_HALF  = 32'd32768;
  localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

  // Move a level toward the target by at most step
  function automatic logic [15:0] approach(input logic [15:0] level,
                                           input logic [15:0] target,
                                           input logic [15:0] step);
    logic [15:0] result;
    result = level;
    if (level > target) begin
      result = ((level - target) > step) ? (level - step) : target;
    end else if (target > level) begin
      result = ((target - level) > step) ? (level + step) : target;
    end
    return result;
  endfunction

  // Lower a level by the stop step, clamping at zero
  function automatic logic [15:0] decay(input logic [15:0] level,
                                        input logic [15:0] step);
    return (level < step) ? 16'd0 : (level - step);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bmrl_duty_map.sv =====
// Two-segment linear map from a Q1.15 drive level to a PWM duty.
`default_nettype none

module bmrl_duty_map
  import bmrl_pkg::*;
(
  input  wire logic [15:0] level,
  output logic      [14:0] duty
);

  logic        upper;
  logic [15:0] rest;
  logic [15:0] coef;
  logic [15:0] operand;
  logic [31:0] product;
  logic [31:0] rounded;
  logic [15:0] scaled;
  logic [15:0] lower_duty;

  // Segment select; one shared multiplier serves both segments
  assign upper   = (level >= KNEE_LEVEL);
  assign rest    = (level >= ONE_Q15) ? 16'd0 : (ONE_Q15 - level);
  assign coef    = upper ? COEF_HIGH : COEF_LOW;
  assign operand = upper ? rest : level;
  assign product = 32'(coef) * 32'(operand);
  assign rounded = product + ROUND_HALF;
  assign scaled  = rounded[31:16];

  // Lower segment subtracts the scaled level from one half
  assign lower_duty = (scaled >= HALF_Q15) ? 16'd0 : (HALF_Q15 - scaled);
  assign duty       = upper ? scaled[14:0] : lower_duty[14:0];

endmodule

`default_nettype wire

// ===== rtl/bidirectional_motor_ramp_limiter.sv =====
// Top level of the two-channel motor drive ramp limiter.
// Usage:
//   Input channel (in_valid/in_ready) carries action, target_level and
//   max_step. A tick advances the saturating millisecond counter; a move or
//   stop command acts only once the counter has reached update_interval_ms.
//   Every item gives exactly one result on the output channel
//   (out_valid/out_ready): mapped duties, the levels after the item and an
//   updated flag.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; index 0 is the update interval, index 1 the stop step,
//   other indexes are ignored. Write only while no item is in flight.
//   From input accept to result valid, the level update sits in the first
//   stage and the duty multiplier in the second.
//   Throughput is one item per cycle while the receiver keeps out_ready high.
//   Reset clears both levels and the counter and loads the register defaults
//   (interval 100, stop step 1638). When the receiver stalls the result is
//   held and the pipeline fills; in_ready drops once both stages are full.
`default_nettype none

module bidirectional_motor_ramp_limiter
  import bmrl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] target_level,
  input  wire logic [15:0] max_step,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [14:0] duty_forward,
  output logic      [14:0] duty_reverse,
  output logic      [15:0] level_forward,
  output logic      [15:0] level_reverse,
  output logic             updated
);

  logic [15:0] update_interval_ms;
  logic [15:0] stop_step;

  logic [15:0] forward_level;
  logic [15:0] reverse_level;
  logic [15:0] elapsed_ms;
  logic [15:0] forward_level_next;
  logic [15:0] reverse_level_next;
  logic [15:0] elapsed_ms_next;
  logic        updated_next;

  logic        s1_valid;
  logic [15:0] s1_forward;
  logic [15:0] s1_reverse;
  logic        s1_updated;

  logic        in_fire;
  logic        out_load;
  logic        s1_advance;

  action_t     act;
  logic [15:0] target_sat;
  logic        counter_due;
  logic        do_stop;
  logic [15:0] moved_level;
  logic [14:0] map_forward;
  logic [14:0] map_reverse;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval_ms <= UPDATE_INTERVAL_RST;
      stop_step          <= STOP_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UPDATE_INTERVAL: update_interval_ms <= cfg_data;
        REG_STOP_STEP:       stop_step          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  assign out_load   = s1_valid && (!out_valid || out_ready);
  assign s1_advance = !s1_valid || out_load;
  assign in_ready   = s1_advance;
  assign in_fire    = in_valid && in_ready;

  // Level update for the incoming item
  assign act         = action_t'(action);
  assign target_sat  = (target_level > ONE_Q15) ? ONE_Q15 : target_level;
  assign counter_due = (elapsed_ms >= update_interval_ms);
  assign do_stop     = (act == ACT_STOP) ||
                       ((act == ACT_FWD) && (reverse_level != 16'd0)) ||
                       ((act == ACT_REV) && (forward_level != 16'd0));
  assign moved_level = approach((act == ACT_REV) ? reverse_level : forward_level,
                                target_sat, max_step);

  always_comb begin
    forward_level_next = forward_level;
    reverse_level_next = reverse_level;
    elapsed_ms_next    = elapsed_ms;
    updated_next       = 1'b0;
    if (act == ACT_TICK) begin
      if (elapsed_ms != COUNTER_MAX) begin
        elapsed_ms_next = elapsed_ms + 16'd1;
      end
    end else if (counter_due) begin
      if (do_stop) begin
        forward_level_next = decay(forward_level, stop_step);
        reverse_level_next = decay(reverse_level, stop_step);
      end else if (act == ACT_FWD) begin
        forward_level_next = moved_level;
      end else begin
        reverse_level_next = moved_level;
      end
      elapsed_ms_next = 16'd0;
      updated_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_level <= 16'd0;
      reverse_level <= 16'd0;
      elapsed_ms    <= 16'd0;
    end else if (in_fire) begin
      forward_level <= forward_level_next;
      reverse_level <= reverse_level_next;
      elapsed_ms    <= elapsed_ms_next;
    end
  end

  // First stage: levels after the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_forward <= forward_level_next;
      s1_reverse <= reverse_level_next;
      s1_updated <= updated_next;
    end
  end

  // Duty mapping
  bmrl_duty_map u_map_forward (
    .level (s1_forward),
    .duty  (map_forward)
  );

  bmrl_duty_map u_map_reverse (
    .level (s1_reverse),
    .duty  (map_reverse)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      duty_forward  <= map_forward;
      duty_reverse  <= map_reverse;
      level_forward <= s1_forward;
      level_reverse <= s1_reverse;
      updated       <= s1_updated;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bmrl_checker.sv =====
// Port-level checker for the motor ramp limiter, bound to the top level.
`default_nettype none

`include "bidirectional_motor_ramp_limiter_macros.svh"

module bmrl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] duty_forward,
  input wire logic [14:0] duty_reverse,
  input wire logic [15:0] level_forward,
  input wire logic [15:0] level_reverse,
  input wire logic        updated
);

  logic [15:0] last_forward;
  logic [15:0] last_reverse;

  // Levels of the last delivered item; both start at zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_forward <= 16'd0;
      last_reverse <= 16'd0;
    end else if (out_valid && out_ready) begin
      last_forward <= level_forward;
      last_reverse <= level_reverse;
    end
  end

  `BMRL_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "result valid after reset")

  `BMRL_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(duty_forward) && $stable(duty_reverse) && $stable(level_forward) && $stable(level_reverse) && $stable(updated), "stalled item changed")

  `BMRL_ASSERT(a_one_side, clk, rst, out_valid |-> (level_forward == 16'd0) || (level_reverse == 16'd0), "both levels nonzero")

  `BMRL_ASSERT(a_level_range, clk, rst, out_valid |-> (level_forward <= 16'd32768) && (level_reverse <= 16'd32768), "level above one")

  `BMRL_ASSERT(a_no_update_keeps, clk, rst, out_valid && !updated |-> (level_forward == last_forward) && (level_reverse == last_reverse), "levels moved without update")

endmodule

bind bidirectional_motor_ramp_limiter bmrl_checker u_bmrl_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .duty_forward  (duty_forward),
  .duty_reverse  (duty_reverse),
  .level_forward (level_forward),
  .level_reverse (level_reverse),
  .updated       (updated)
);

`default_nettype wire

// ===== sim/bidirectional_motor_ramp_limiter_tb.sv =====
// Self-checking testbench for the two-channel motor ramp limiter: directed table, then random phases.
module bidirectional_motor_ramp_limiter_tb
  import bmrl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Q1.15 constants of the ramp and the duty curve
  localparam int unsigned Q15_ONE       = 32768;
  localparam int unsigned DUTY_AT_ZERO  = 16384;
  localparam int unsigned KNEE          = 17630;
  localparam int unsigned SLOPE_HIGH    = 7098;
  localparam int unsigned SLOPE_LOW     = 54768;
  localparam int unsigned ROUNDING      = 32768;
  localparam int unsigned ELAPSED_MAX   = 65535;
  localparam int unsigned RST_INTERVAL  = 100;
  localparam int unsigned RST_STOP_STEP = 1638;
  localparam logic [3:0]  REG_UNUSED_TOP = 4'd15;

  localparam int CLK_HALF    = 6;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int BURST_TICKS = 24;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [14:0] duty_f;
    logic [14:0] duty_r;
    logic [15:0] lvl_f;
    logic [15:0] lvl_r;
    logic        upd;
  } ramp_out_t;

  typedef struct packed {
    action_t     act;
    logic [15:0] tgt;
    logic [15:0] stp;
    logic        known;
    ramp_out_t   typed;
  } ramp_item_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  idx;
    action_t     act;
    logic [15:0] a;
    logic [15:0] b;
    logic        known;
    ramp_out_t   res;
  } dir_row_t;

  // Results that can be read straight off the behaviour
  localparam ramp_out_t RES_RESET    = '{15'd16384, 15'd16384, 16'd0, 16'd0, 1'b0};
  localparam ramp_out_t RES_CLEARED  = '{15'd16384, 15'd16384, 16'd0, 16'd0, 1'b1};
  localparam ramp_out_t RES_FWD_FULL = '{15'd0, 15'd16384, 16'd32768, 16'd0, 1'b1};
  localparam ramp_out_t RES_NONE     = '0;

  // Directed stimulus; register rows carry the write data in field a
  dir_row_t dir_rows [26] = '{
    '{ROW_ITEM, 4'd0, ACT_TICK, 16'd0,     16'd0,     1'b1, RES_RESET},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'd32768, 16'd32768, 1'b1, RES_RESET},
    '{ROW_ITEM, 4'd0, ACT_STOP, 16'd0,     16'd0,     1'b1, RES_RESET},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'hFFFF,  16'hFFFF,  1'b1, RES_RESET},
    '{ROW_REG,  REG_UPDATE_INTERVAL, ACT_TICK, 16'd0,     16'd0, 1'b0, RES_NONE},
    '{ROW_REG,  REG_STOP_STEP,       ACT_TICK, 16'd32768, 16'd0, 1'b0, RES_NONE},
    '{ROW_REG,  REG_UNUSED_TOP,      ACT_TICK, 16'hFFFF,  16'd0, 1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'd32768, 16'd32768, 1'b1, RES_FWD_FULL},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'd100,   16'd5,     1'b1, RES_CLEARED},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'hFFFF,  16'hFFFF,  1'b1, RES_FWD_FULL},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'd32768, 16'd0,     1'b1, RES_FWD_FULL},
    '{ROW_ITEM, 4'd0, ACT_STOP, 16'd0,     16'd0,     1'b1, RES_CLEARED},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'd0,     16'd0,     1'b1, RES_CLEARED},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'd17630, 16'hFFFF,  1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'd17629, 16'd1,     1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'd40000, 16'd1000,  1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_TICK, 16'd0,     16'd0,     1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'd5,     16'd7,     1'b1, RES_CLEARED},
    '{ROW_REG,  REG_STOP_STEP,       ACT_TICK, 16'd1000,  16'd0, 1'b0, RES_NONE},
    '{ROW_REG,  REG_UPDATE_INTERVAL, ACT_TICK, 16'd1,     16'd0, 1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'd20000, 16'hFFFF,  1'b1, RES_RESET},
    '{ROW_ITEM, 4'd0, ACT_TICK, 16'd0,     16'd0,     1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_FWD,  16'd20000, 16'hFFFF,  1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_TICK, 16'd0,     16'd0,     1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_STOP, 16'd0,     16'd0,     1'b0, RES_NONE},
    '{ROW_ITEM, 4'd0, ACT_REV,  16'd3,     16'd3,     1'b0, RES_NONE}
  };

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [15:0] target_level;
  logic [15:0] max_step;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] duty_forward;
  logic [14:0] duty_reverse;
  logic [15:0] level_forward;
  logic [15:0] level_reverse;
  logic        updated;

  // Item on offer; the payload ports follow it
  ramp_item_t offer = '0;
  assign action       = offer.act;
  assign target_level = offer.tgt;
  assign max_step     = offer.stp;

  ramp_item_t tx_q[$];
  ramp_out_t  levels_q[$];

  // Shadow state of the ramper
  int unsigned m_fwd, m_rev, m_elapsed, m_interval, m_stop_step;

  int  pushed      = 0;
  int  accepted    = 0;
  int  acted_count = 0;
  int  reg_writes  = 0;
  int  err_count   = 0;
  int  cycle_count = 0;
  bit  send_idle   = 1'b1;
  bit  recv_idle   = 1'b1;
  bit  hold_req    = 1'b0;

  bidirectional_motor_ramp_limiter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .target_level (target_level),
    .max_step     (max_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty_forward (duty_forward),
    .duty_reverse (duty_reverse),
    .level_forward(level_forward),
    .level_reverse(level_reverse),
    .updated      (updated)
  );

  // Two-segment duty curve, rounded half up
  function automatic logic [14:0] level_to_duty(input int unsigned lvl);
    int unsigned rest;
    int unsigned drop;
    if (lvl >= KNEE) begin
      rest = (lvl >= Q15_ONE) ? 0 : Q15_ONE - lvl;
      return 15'((SLOPE_HIGH * rest + ROUNDING) >> 16);
    end
    drop = (SLOPE_LOW * lvl + ROUNDING) >> 16;
    return (drop >= DUTY_AT_ZERO) ? 15'd0 : 15'(DUTY_AT_ZERO - drop);
  endfunction

  // Slew a level toward its target, limited by the step
  function automatic int unsigned slew_toward(input int unsigned lvl, input int unsigned tgt,
                                              input int unsigned stp);
    if (lvl > tgt) return (lvl - tgt > stp) ? lvl - stp : tgt;
    if (tgt > lvl) return (tgt - lvl > stp) ? lvl + stp : tgt;
    return lvl;
  endfunction

  function automatic int unsigned bleed(input int unsigned lvl);
    return (lvl < m_stop_step) ? 0 : lvl - m_stop_step;
  endfunction

  // Apply one item to the shadow state and give the result it should produce
  function automatic ramp_out_t advance_ramp(input ramp_item_t it);
    int unsigned tgt;
    bit          stop_now;
    ramp_out_t   r;
    tgt   = (it.tgt > Q15_ONE) ? Q15_ONE : it.tgt;
    r.upd = 1'b0;
    if (it.act == ACT_TICK) begin
      if (m_elapsed < ELAPSED_MAX) m_elapsed++;
    end else if (m_elapsed >= m_interval) begin
      stop_now = (it.act == ACT_STOP) || (it.act == ACT_FWD && m_rev != 0) ||
                 (it.act == ACT_REV && m_fwd != 0);
      if (stop_now) begin
        m_fwd = bleed(m_fwd);
        m_rev = bleed(m_rev);
      end else if (it.act == ACT_FWD) begin
        m_fwd = slew_toward(m_fwd, tgt, it.stp);
      end else begin
        m_rev = slew_toward(m_rev, tgt, it.stp);
      end
      m_elapsed = 0;
      r.upd     = 1'b1;
    end
    r.duty_f = level_to_duty(m_fwd);
    r.duty_r = level_to_duty(m_rev);
    r.lvl_f  = 16'(m_fwd);
    r.lvl_r  = 16'(m_rev);
    return r;
  endfunction

  // Targets lean on the saturation point and the knee of the curve
  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'(Q15_ONE);
      2: return 16'hFFFF;
      3: return 16'(KNEE);
      4: return 16'(KNEE - 1);
      5: return 16'($urandom);
      default: return 16'($urandom_range(0, Q15_ONE));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'(Q15_ONE);
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, 6000));
    endcase
  endfunction

  task automatic queue_item(input action_t a, input logic [15:0] t, input logic [15:0] s);
    ramp_item_t it;
    it       = '0;
    it.act   = a;
    it.tgt   = t;
    it.stp   = s;
    tx_q.push_back(it);
    pushed++;
  endtask

  // Wait until every queued item is in and every result is out
  task automatic flush_items();
    while (accepted != pushed || levels_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Sender: random gap before each item, then hold it until taken
  initial begin
    int         gap;
    ramp_item_t it;
    in_valid = 1'b0;
    forever begin
      @(negedge clk);
      if (tx_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        it  = tx_q.pop_front();
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        offer    <= it;
        do @(posedge clk); while (!in_ready);
      end
    end
  end

  // Receiver: random stall per result, plus an occasional long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = recv_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Monitor: track register writes, predict each item, check each result
  always @(posedge clk) begin
    ramp_out_t want;
    ramp_out_t got;
    if (rst) begin
      m_fwd       = 0;
      m_rev       = 0;
      m_elapsed   = 0;
      m_interval  = RST_INTERVAL;
      m_stop_step = RST_STOP_STEP;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UPDATE_INTERVAL: m_interval  = cfg_data;
          REG_STOP_STEP:       m_stop_step = cfg_data;
          default: ;
        endcase
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        want = advance_ramp(offer);
        if (offer.known) want = offer.typed;
        levels_q.push_back(want);
        accepted++;
      end
      if (out_valid && out_ready) begin
        got = '{duty_forward, duty_reverse, level_forward, level_reverse, updated};
        if (got.upd === 1'b1) acted_count++;
        if (levels_q.size() == 0) begin
          $error("result item with no item outstanding");
          err_count++;
        end else begin
          want = levels_q.pop_front();
          if (got.duty_f !== want.duty_f) begin
            $error("duty_forward: expected %0d, got %0d", want.duty_f, got.duty_f);
            err_count++;
          end
          if (got.duty_r !== want.duty_r) begin
            $error("duty_reverse: expected %0d, got %0d", want.duty_r, got.duty_r);
            err_count++;
          end
          if (got.lvl_f !== want.lvl_f) begin
            $error("level_forward: expected %0d, got %0d", want.lvl_f, got.lvl_f);
            err_count++;
          end
          if (got.lvl_r !== want.lvl_r) begin
            $error("level_reverse: expected %0d, got %0d", want.lvl_r, got.lvl_r);
            err_count++;
          end
          if (got.upd !== want.upd) begin
            $error("updated: expected %0d, got %0d", want.upd, got.upd);
            err_count++;
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    ramp_item_t  it;
    action_t     dir;
    logic [15:0] interval_val;
    logic [15:0] stop_val;
    int          n;
    int          k;
    bit          half_done;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        flush_items();
        write_reg(dir_rows[i].idx, dir_rows[i].a);
      end else begin
        it       = '0;
        it.act   = dir_rows[i].act;
        it.tgt   = dir_rows[i].a;
        it.stp   = dir_rows[i].b;
        it.known = dir_rows[i].known;
        it.typed = dir_rows[i].res;
        tx_q.push_back(it);
        pushed++;
      end
    end

    // Counter one short of the interval, then past it, with the widest stop step
    flush_items();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(REG_UPDATE_INTERVAL, 16'(BURST_TICKS + 1));
    write_reg(REG_STOP_STEP, 16'hFFFF);
    repeat (BURST_TICKS) queue_item(ACT_TICK, 16'($urandom), 16'($urandom));
    queue_item(ACT_FWD, 16'd32768, 16'd20000);
    repeat (2) queue_item(ACT_TICK, 16'd0, 16'd0);
    queue_item(ACT_FWD, 16'd32768, 16'd20000);
    queue_item(ACT_REV, 16'd32768, 16'd20000);

    // Random phases: mostly tick runs that reach the interval, then a command
    dir = ACT_FWD;
    for (int ph = 0; ph < PHASES; ph++) begin
      flush_items();
      case ($urandom_range(0, 3))
        0: interval_val = 16'd0;
        1: interval_val = 16'd1;
        default: interval_val = 16'($urandom_range(2, 5));
      endcase
      case ($urandom_range(0, 5))
        0: stop_val = 16'd0;
        1: stop_val = 16'(Q15_ONE);
        2: stop_val = 16'hFFFF;
        3: stop_val = 16'($urandom);
        default: stop_val = 16'($urandom_range(1, 4000));
      endcase
      write_reg(4'($urandom_range(REG_STOP_STEP + 1, REG_UNUSED_TOP)), 16'($urandom));
      write_reg(REG_UPDATE_INTERVAL, interval_val);
      write_reg(REG_STOP_STEP, stop_val);
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
      n         = 0;
      half_done = 1'b0;
      while (n < PHASE_ITEMS) begin
        // halfway: either starve the output or let the pipeline drain
        if (!half_done && n >= PHASE_ITEMS / 2) begin
          half_done = 1'b1;
          while (tx_q.size() != 0) @(posedge clk);
          if (ph % 2 == 0) hold_req = 1'b1;
          else flush_items();
        end
        if ($urandom_range(0, 15) == 0) begin
          send_idle = ($urandom_range(0, 2) != 0);
          recv_idle = ($urandom_range(0, 2) != 0);
        end
        if ($urandom_range(0, 9) < 8) begin
          k = interval_val;
          if ($urandom_range(0, 3) == 0) k = k + $urandom_range(0, 2);
          else if (k > 0 && $urandom_range(0, 7) == 0) k = k - 1;
          repeat (k) queue_item(ACT_TICK, 16'($urandom), 16'($urandom));
          if ($urandom_range(0, 7) == 0) dir = (dir == ACT_FWD) ? ACT_REV : ACT_FWD;
          if ($urandom_range(0, 9) == 0) queue_item(ACT_STOP, pick_level(), pick_step());
          else queue_item(dir, pick_level(), pick_step());
          n = n + k + 1;
        end else begin
          queue_item(action_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
          n++;
        end
      end
    end

    flush_items();
    $display("Checked %0d items over %0d cycles: %0d level updates, %0d register writes.",
             accepted, cycle_count, acted_count, reg_writes);
    $display("Run took in the interval edge, full-scale steps, decays and output hold-offs.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
